@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the compensation pipeline modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/bpc_pkg.sv @@
// Types, widths, constants and helper functions of the pressure compensation block.
package bpc_pkg;

	localparam int RAW_W = 24;          // raw conversion width
	localparam int CAL_W = 16;          // calibration word width
	localparam int OUT_W = 32;          // result field width
	localparam int DTW   = RAW_W + 1;   // dT, signed
	localparam int MW    = DTW + CAL_W + 1; // dT times a calibration word
	localparam int MDW   = 2 * DTW;     // dT squared
	localparam int TW    = 20;          // temperature, signed
	localparam int WW    = 40;          // offset and sensitivity, signed
	localparam int T2W   = 18;          // second-order temperature term
	localparam int SQW   = 19;          // sensitivity after the 2^21 scale
	localparam int PW    = 44;          // raw pressure times scaled sensitivity
	localparam int DW    = 52;          // scratch width for scaled divisions

	localparam int SH_TEMP = 23;
	localparam int SH_OFF  = 7;
	localparam int SH_SENS = 8;
	localparam int SH_T2   = 31;
	localparam int SH_SQ   = 21;
	localparam int SH_P    = 15;

	localparam logic signed [TW-1:0] TEMP_REF = TW'(2000);
	localparam logic signed [TW-1:0] TEMP_VLO = TW'(-1500);
	localparam logic signed [TW-1:0] TEMP_HI  = TW'(4500);

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_PRESS_SENS = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFF_TC     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_REF_TEMP   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_TEMP_TC    = 3'd5;

	typedef struct packed {
		logic [CAL_W-1:0] pressure_sensitivity;
		logic [CAL_W-1:0] pressure_offset;
		logic [CAL_W-1:0] sensitivity_temp_coeff;
		logic [CAL_W-1:0] offset_temp_coeff;
		logic [CAL_W-1:0] reference_temperature;
		logic [CAL_W-1:0] temperature_coeff;
	} cal_t;

	// First-order terms handed to the correction stages
	typedef struct packed {
		logic [RAW_W-1:0]        d1;
		logic signed [TW-1:0]    temp;
		logic signed [WW-1:0]    off;
		logic signed [WW-1:0]    sens;
		logic [T2W-1:0]          t2;
	} front_t;

	// Corrected terms handed to the pressure stages
	typedef struct packed {
		logic [RAW_W-1:0]        d1;
		logic signed [TW-1:0]    temp;
		logic signed [WW-1:0]    off;
		logic signed [WW-1:0]    sens;
	} corr_t;

	// Signed divide by 2^k, rounding toward zero.
	function automatic logic signed [DW-1:0] trunc_shr(input logic signed [DW-1:0] x,
			input int unsigned k);
		logic [DW-1:0] mask;
		logic signed [DW-1:0] bias;
		mask = ~({DW{1'b1}} << k);
		bias = x[DW-1] ? $signed(mask) : '0;
		return (x + bias) >>> k;
	endfunction

	// Clamp to the signed 32-bit range.
	function automatic logic signed [OUT_W-1:0] sat32(input logic signed [DW-1:0] x);
		logic fits;
		fits = (x[DW-1:OUT_W-1] == '0) || (x[DW-1:OUT_W-1] == '1);
		if (fits)
			return x[OUT_W-1:0];
		else if (x[DW-1])
			return {1'b1, {(OUT_W-1){1'b0}}};
		else
			return {1'b0, {(OUT_W-1){1'b1}}};
	endfunction

endpackage

@@ rtl/core/barometric_pressure_compensation.sv @@
// Barometric pressure compensation: eight-stage pipeline from raw conversions to
// compensated pressure and temperature. One raw pair is accepted every cycle while
// the output is not stalled; the register stages sit around the dT products, the
// squares of the second-order branch and the D1 by SENS multiply. Each stage holds
// its beat while the stage after it is full and cannot move on, so a stall on the
// output fills the empty stages first and then lowers s_axis_tready. Calibration
// writes take effect at once and are meant to be made while no beat is inside the
// pipeline.
module barometric_pressure_compensation (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [2*bpc_pkg::RAW_W-1:0]         s_axis_tdata,  // raw_pressure, raw_temperature
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [2*bpc_pkg::OUT_W-1:0]         m_axis_tdata,  // pressure, temperature
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [bpc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]           cfg_data
);

	bpc_pkg::cal_t   cal;
	bpc_pkg::front_t front_data;
	bpc_pkg::corr_t  corr_data;
	logic            front_valid, front_ready;
	logic            corr_valid, corr_ready;
	logic signed [bpc_pkg::OUT_W-1:0] pressure, temperature;

	bpc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cal       (cal)
	);

	bpc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cal             (cal),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.raw_pressure    (s_axis_tdata[bpc_pkg::RAW_W-1:0]),
		.raw_temperature (s_axis_tdata[2*bpc_pkg::RAW_W-1:bpc_pkg::RAW_W]),
		.out_valid       (front_valid),
		.out_ready       (front_ready),
		.out_data        (front_data)
	);

	bpc_corr u_corr (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_data   (front_data),
		.out_valid (corr_valid),
		.out_ready (corr_ready),
		.out_data  (corr_data)
	);

	bpc_press u_press (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (corr_valid),
		.in_ready    (corr_ready),
		.in_data     (corr_data),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.pressure    (pressure),
		.temperature (temperature)
	);

	assign m_axis_tdata = {temperature, pressure};

endmodule

@@ rtl/core/bpc_cfg.sv @@
// Calibration register file written through the configuration channel.
module bpc_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bpc_pkg::REG_IDX_W-1:0]      cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]          cfg_data,
	output bpc_pkg::cal_t                      cal
);

	bpc_pkg::cal_t cal_q;

	assign cfg_ready = 1'b1;
	assign cal       = cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				bpc_pkg::REG_PRESS_SENS: cal_q.pressure_sensitivity   <= cfg_data;
				bpc_pkg::REG_PRESS_OFF:  cal_q.pressure_offset        <= cfg_data;
				bpc_pkg::REG_SENS_TC:    cal_q.sensitivity_temp_coeff <= cfg_data;
				bpc_pkg::REG_OFF_TC:     cal_q.offset_temp_coeff      <= cfg_data;
				bpc_pkg::REG_REF_TEMP:   cal_q.reference_temperature  <= cfg_data;
				bpc_pkg::REG_TEMP_TC:    cal_q.temperature_coeff      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

@@ rtl/core/bpc_front.sv @@
// First-order stages: dT, the four products, then TEMP, OFF, SENS and T2.
`include "assert_macros.svh"

module bpc_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  bpc_pkg::cal_t                  cal,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bpc_pkg::RAW_W-1:0]      raw_pressure,
	input  logic [bpc_pkg::RAW_W-1:0]      raw_temperature,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bpc_pkg::front_t                out_data
);

	logic v_s1, v_s2, v_s3;
	logic en_s1, en_s2, en_s3;

	logic [bpc_pkg::RAW_W-1:0]         d1_s1, d1_s2;
	logic signed [bpc_pkg::DTW-1:0]    dt_s1;
	logic signed [bpc_pkg::MW-1:0]     m6_s2, m4_s2, m3_s2;
	logic signed [bpc_pkg::MDW-1:0]    mdd_s2;
	bpc_pkg::front_t                   st_s3;

	logic signed [bpc_pkg::DTW-1:0]    dt_c;
	logic signed [bpc_pkg::MW-1:0]     m6_c, m4_c, m3_c;
	logic signed [bpc_pkg::MDW-1:0]    mdd_c;
	logic signed [bpc_pkg::DW-1:0]     q6_c, q4_c, q3_c, off_c, sens_c;

	assign en_s3    = !v_s3 || out_ready;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= in_valid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
		end
	end

	// dT = D2 - C5 * 256
	assign dt_c = $signed({1'b0, raw_temperature})
		- $signed({1'b0, cal.reference_temperature, 8'h00});

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			d1_s1 <= raw_pressure;
			dt_s1 <= dt_c;
		end
	end

	assign m6_c  = dt_s1 * $signed({1'b0, cal.temperature_coeff});
	assign m4_c  = dt_s1 * $signed({1'b0, cal.offset_temp_coeff});
	assign m3_c  = dt_s1 * $signed({1'b0, cal.sensitivity_temp_coeff});
	assign mdd_c = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			d1_s2  <= d1_s1;
			m6_s2  <= m6_c;
			m4_s2  <= m4_c;
			m3_s2  <= m3_c;
			mdd_s2 <= mdd_c;
		end
	end

	always_comb begin
		q6_c   = bpc_pkg::trunc_shr(bpc_pkg::DW'(m6_s2), bpc_pkg::SH_TEMP);
		q4_c   = bpc_pkg::trunc_shr(bpc_pkg::DW'(m4_s2), bpc_pkg::SH_OFF);
		q3_c   = bpc_pkg::trunc_shr(bpc_pkg::DW'(m3_s2), bpc_pkg::SH_SENS);
		off_c  = $signed(bpc_pkg::DW'({cal.pressure_offset, 16'h0000})) + q4_c;
		sens_c = $signed(bpc_pkg::DW'({cal.pressure_sensitivity, 15'h0000})) + q3_c;
	end

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			st_s3.d1   <= d1_s2;
			st_s3.temp <= bpc_pkg::TW'(q6_c) + bpc_pkg::TEMP_REF;
			st_s3.off  <= bpc_pkg::WW'(off_c);
			st_s3.sens <= bpc_pkg::WW'(sens_c);
			// dT^2 is never negative, so a plain shift truncates correctly
			st_s3.t2   <= mdd_s2[bpc_pkg::SH_T2 +: bpc_pkg::T2W];
		end
	end

	assign out_valid = v_s3;
	assign out_data  = st_s3;

	`ASSERT_NEXT(a_front_hold, clk, arst_n, v_s3 && !out_ready, v_s3 && $stable(st_s3), "front: stalled beat changed")
	`ASSERT_NEXT(a_front_stall2, clk, arst_n, v_s2 && !en_s2, v_s2 && $stable(m6_s2), "front: stage 2 lost a stalled beat")

endmodule

@@ rtl/core/bpc_corr.sv @@
// Second-order correction stages: squares and branch flags, then OFF2 and SENS2.
`include "assert_macros.svh"

module bpc_corr (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bpc_pkg::front_t       in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bpc_pkg::corr_t        out_data
);

	logic v_s4, v_s5;
	logic en_s4, en_s5;

	logic [bpc_pkg::RAW_W-1:0]        d1_s4;
	logic signed [bpc_pkg::TW-1:0]    temp_s4;
	logic signed [bpc_pkg::WW-1:0]    off_s4, sens_s4;
	logic signed [bpc_pkg::WW-1:0]    aa_s4, bb_s4, hh_s4;
	logic                             lo_s4, vlo_s4, hi_s4;
	bpc_pkg::corr_t                   st_s5;

	logic signed [bpc_pkg::TW-1:0]    a_c, b_c, h_c;
	logic signed [bpc_pkg::WW-1:0]    off2_c, sens2_c;

	assign en_s5    = !v_s5 || out_ready;
	assign en_s4    = !v_s4 || en_s5;
	assign in_ready = en_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en_s4) v_s4 <= in_valid;
			if (en_s5) v_s5 <= v_s4;
		end
	end

	assign a_c = in_data.temp - bpc_pkg::TEMP_REF;
	assign b_c = in_data.temp - bpc_pkg::TEMP_VLO;
	assign h_c = in_data.temp - bpc_pkg::TEMP_HI;

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			d1_s4   <= in_data.d1;
			// T2 only comes off below the reference; branch tests look at TEMP before that
			temp_s4 <= (in_data.temp < bpc_pkg::TEMP_REF)
				? in_data.temp - $signed(bpc_pkg::TW'(in_data.t2)) : in_data.temp;
			off_s4  <= in_data.off;
			sens_s4 <= in_data.sens;
			aa_s4   <= a_c * a_c;
			bb_s4   <= b_c * b_c;
			hh_s4   <= h_c * h_c;
			lo_s4   <= in_data.temp < bpc_pkg::TEMP_REF;
			vlo_s4  <= in_data.temp < bpc_pkg::TEMP_VLO;
			hi_s4   <= in_data.temp >= bpc_pkg::TEMP_HI;
		end
	end

	// squares are non-negative, so arithmetic shifts truncate as required
	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (lo_s4) begin
			off2_c  = (aa_s4 <<< 1) + aa_s4;
			sens2_c = ((aa_s4 <<< 3) - aa_s4) >>> 3;
			if (vlo_s4)
				sens2_c = sens2_c + (bb_s4 <<< 1);
		end else if (hi_s4) begin
			sens2_c = -(hh_s4 >>> 3);
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5 && v_s4) begin
			st_s5.d1   <= d1_s4;
			st_s5.temp <= temp_s4;
			st_s5.off  <= off_s4 - off2_c;
			st_s5.sens <= sens_s4 - sens2_c;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = st_s5;

	`ASSERT_IMPL(a_corr_branch, clk, arst_n, v_s4, !(lo_s4 && hi_s4) && (!vlo_s4 || lo_s4), "corr: temperature branches overlap")

endmodule

@@ rtl/core/bpc_press.sv @@
// Pressure stages: scale SENS, multiply by D1, subtract OFF, scale and clamp.
`include "assert_macros.svh"

module bpc_press (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  bpc_pkg::corr_t                   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [bpc_pkg::OUT_W-1:0] pressure,
	output logic signed [bpc_pkg::OUT_W-1:0] temperature
);

	logic v_s6, v_s7, v_s8;
	logic en_s6, en_s7, en_s8;

	logic [bpc_pkg::RAW_W-1:0]           d1_s6;
	logic signed [bpc_pkg::SQW-1:0]      sq_s6;
	logic signed [bpc_pkg::WW-1:0]       off_s6, off_s7;
	logic signed [bpc_pkg::TW-1:0]       temp_s6, temp_s7;
	logic signed [bpc_pkg::PW-1:0]       prod_s7;
	logic signed [bpc_pkg::OUT_W-1:0]    pressure_s8, temperature_s8;

	logic signed [bpc_pkg::DW-1:0]       sq_c, p_c;
	logic signed [bpc_pkg::PW-1:0]       diff_c;

	assign en_s8    = !v_s8 || out_ready;
	assign en_s7    = !v_s7 || en_s8;
	assign en_s6    = !v_s6 || en_s7;
	assign in_ready = en_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (en_s6) v_s6 <= in_valid;
			if (en_s7) v_s7 <= v_s6;
			if (en_s8) v_s8 <= v_s7;
		end
	end

	// SENS is scaled down before the multiply; the lost bits are intended
	assign sq_c = bpc_pkg::trunc_shr(bpc_pkg::DW'(in_data.sens), bpc_pkg::SH_SQ);

	always_ff @(posedge clk) begin
		if (en_s6 && in_valid) begin
			d1_s6   <= in_data.d1;
			sq_s6   <= bpc_pkg::SQW'(sq_c);
			off_s6  <= in_data.off;
			temp_s6 <= in_data.temp;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && v_s6) begin
			prod_s7 <= $signed({1'b0, d1_s6}) * sq_s6;
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
		end
	end

	assign diff_c = prod_s7 - bpc_pkg::PW'(off_s7);
	assign p_c    = bpc_pkg::trunc_shr(bpc_pkg::DW'(diff_c), bpc_pkg::SH_P);

	always_ff @(posedge clk) begin
		if (en_s8 && v_s7) begin
			pressure_s8    <= bpc_pkg::sat32(p_c);
			temperature_s8 <= bpc_pkg::sat32(bpc_pkg::DW'(temp_s7));
		end
	end

	assign out_valid   = v_s8;
	assign pressure    = pressure_s8;
	assign temperature = temperature_s8;

	`ASSERT_NEXT(a_press_fill, clk, arst_n, v_s7 && en_s8, v_s8, "press: beat dropped into output stage")
	`ASSERT_NEXT(a_press_drain, clk, arst_n, v_s8 && out_ready && !v_s7, !v_s8, "press: taken beat repeated")

endmodule

@@ bench/compensation_checker.sv @@
// Watches the pressure compensation channels, predicts each reading and compares it.
`timescale 1ns / 100ps
module compensation_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	input  logic                          s_tready,
	input  logic [2*bpc_pkg::RAW_W-1:0]   s_tdata,  // raw_pressure, raw_temperature
	input  logic                          m_tvalid,
	input  logic                          m_tready,
	input  logic [2*bpc_pkg::OUT_W-1:0]   m_tdata,  // pressure, temperature
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [bpc_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CAL_W-1:0]     cfg_data,
	output int                            fail_count,
	output int                            pending
);
	import bpc_pkg::*;

	localparam longint T2_SCALE = 64'sd2147483648;
	localparam longint S32_MAX  = 64'sd2147483647;
	localparam longint S32_MIN  = -64'sd2147483648;

	typedef struct packed {
		logic signed [OUT_W-1:0] pressure;
		logic signed [OUT_W-1:0] temperature;
	} reading_t;

	cal_t     cal_words;
	reading_t expected_readings[$];

	function automatic logic signed [OUT_W-1:0] clamp32(input longint v);
		if (v > S32_MAX)
			return OUT_W'(S32_MAX);
		if (v < S32_MIN)
			return OUT_W'(S32_MIN);
		return OUT_W'(v);
	endfunction

	// First-order terms, then the second-order correction by temperature branch.
	function automatic reading_t compensate_reading(input cal_t c,
			input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
		longint d1, d2, c1, c2, c3, c4, c5, c6;
		longint dt, t, off, sens, t2, off2, sens2, a, b, h, p;
		reading_t r;
		d1 = raw_p;
		d2 = raw_t;
		c1 = c.pressure_sensitivity;
		c2 = c.pressure_offset;
		c3 = c.sensitivity_temp_coeff;
		c4 = c.offset_temp_coeff;
		c5 = c.reference_temperature;
		c6 = c.temperature_coeff;
		dt   = d2 - c5 * 256;
		t    = 2000 + (dt * c6) / 8388608;
		off  = c2 * 65536 + (c4 * dt) / 128;
		sens = c1 * 32768 + (c3 * dt) / 256;
		t2    = 0;
		off2  = 0;
		sens2 = 0;
		if (t < 2000) begin
			a     = t - 2000;
			t2    = (dt * dt) / T2_SCALE;
			off2  = 3 * (a * a);
			sens2 = (7 * (a * a)) / 8;
			if (t < -1500) begin
				b     = t + 1500;
				sens2 = sens2 + 2 * (b * b);
			end
		end else if (t >= 4500) begin
			h     = t - 4500;
			sens2 = -((h * h) / 8);
		end
		t    = t - t2;
		off  = off - off2;
		sens = sens - sens2;
		// sensitivity is scaled down before the multiply, truncation included
		p = (d1 * (sens / 2097152) - off) / 32768;
		r.pressure    = clamp32(p);
		r.temperature = clamp32(t);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		reading_t want, got;
		if (!arst_n) begin
			cal_words = '0;
			expected_readings.delete();
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_PRESS_SENS: cal_words.pressure_sensitivity   = cfg_data;
					REG_PRESS_OFF:  cal_words.pressure_offset        = cfg_data;
					REG_SENS_TC:    cal_words.sensitivity_temp_coeff = cfg_data;
					REG_OFF_TC:     cal_words.offset_temp_coeff      = cfg_data;
					REG_REF_TEMP:   cal_words.reference_temperature  = cfg_data;
					REG_TEMP_TC:    cal_words.temperature_coeff      = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.pressure    = m_tdata[OUT_W-1:0];
				got.temperature = m_tdata[2*OUT_W-1:OUT_W];
				if (expected_readings.size() == 0) begin
					$display("%0t: unexpected result beat, pressure %0d temperature %0d",
						$time, got.pressure, got.temperature);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_readings.pop_front();
					if (got.pressure !== want.pressure) begin
						$display("%0t: pressure mismatch, expected %0d, got %0d",
							$time, want.pressure, got.pressure);
						fail_count <= fail_count + 1;
					end
					if (got.temperature !== want.temperature) begin
						$display("%0t: temperature mismatch, expected %0d, got %0d",
							$time, want.temperature, got.temperature);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (s_tvalid && s_tready)
				expected_readings.push_back(compensate_reading(cal_words,
					s_tdata[RAW_W-1:0], s_tdata[2*RAW_W-1:RAW_W]));
			pending <= expected_readings.size();
		end
	end

endmodule

@@ bench/tb_barometric_pressure_compensation.sv @@
// Stimulus, idling, watchdog and verdict for the pressure compensation block.
`timescale 1ns / 100ps
module tb_barometric_pressure_compensation;
	import bpc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 20;
	localparam int PHASE_ITEMS    = 100;
	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};
	// indexes past the last calibration word, writes there are dropped
	localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_valid   = 1'b0;
	logic                   s_ready;
	logic [2*RAW_W-1:0]     s_data    = '0;
	logic                   m_valid;
	logic                   m_ready   = 1'b0;
	logic [2*OUT_W-1:0]     m_data;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [REG_IDX_W-1:0]   cfg_index = '0;
	logic [CAL_W-1:0]       cfg_data  = '0;
	logic                   hold_go   = 1'b0;
	logic                   hold_done = 1'b0;
	int                     hold_left = 0;
	int                     send_idle_pct = 0;
	int                     recv_idle_pct = 0;
	int                     stall_cycles;
	int                     fail_count;
	int                     pending;
	cal_t                   cur_cal = '0;

	always #4 clk = ~clk;

	barometric_pressure_compensation DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_valid),
		.s_axis_tready (s_ready),
		.s_axis_tdata  (s_data),
		.m_axis_tvalid (m_valid),
		.m_axis_tready (m_ready),
		.m_axis_tdata  (m_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	compensation_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_valid),
		.s_tready   (s_ready),
		.s_tdata    (s_data),
		.m_tvalid   (m_valid),
		.m_tready   (m_ready),
		.m_tdata    (m_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// Output side: random back-pressure plus one long hold-off on request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_ready   <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_go && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= HOLD_CYCLES;
			m_ready   <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_ready   <= 1'b0;
		end else begin
			m_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Any beat on any channel counts as progress.
	initial begin
		stall_cycles = 0;
		while (stall_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (s_valid && s_ready) || (m_valid && m_ready)
					|| (cfg_valid && cfg_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
		end
		$display("tb_barometric_pressure_compensation: FAIL");
		$finish;
	end

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CAL_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Only called with the pipeline empty.
	task automatic load_cal(input cal_t c);
		write_reg(REG_PRESS_SENS, c.pressure_sensitivity);
		write_reg(REG_PRESS_OFF,  c.pressure_offset);
		write_reg(REG_SENS_TC,    c.sensitivity_temp_coeff);
		write_reg(REG_OFF_TC,     c.offset_temp_coeff);
		write_reg(REG_REF_TEMP,   c.reference_temperature);
		write_reg(REG_TEMP_TC,    c.temperature_coeff);
		// stray write after the real ones, must not alias onto any word
		write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CAL_W'($urandom));
		cfg_valid <= 1'b0;
		cur_cal = c;
	endtask

	task automatic send_pair(input logic [RAW_W-1:0] raw_p, input logic [RAW_W-1:0] raw_t);
		while ($urandom_range(99) < send_idle_pct) begin
			s_valid <= 1'b0;
			@(posedge clk);
		end
		s_valid <= 1'b1;
		s_data  <= {raw_t, raw_p};
		do @(posedge clk); while (!s_ready);
	endtask

	task automatic drain();
		s_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	function automatic cal_t rand_cal();
		cal_t c;
		c.pressure_sensitivity   = CAL_W'($urandom);
		c.pressure_offset        = CAL_W'($urandom);
		c.sensitivity_temp_coeff = CAL_W'($urandom);
		c.offset_temp_coeff      = CAL_W'($urandom);
		c.reference_temperature  = CAL_W'($urandom);
		c.temperature_coeff      = CAL_W'($urandom);
		return c;
	endfunction

	// Half the temperatures land near the reference point at a random scale,
	// so the branch edges around 20, -15 and 45 degrees get exercised.
	function automatic logic [RAW_W-1:0] pick_raw_temp();
		longint ref_t, span, v;
		if ($urandom_range(1))
			return RAW_W'($urandom);
		ref_t = {cur_cal.reference_temperature, 8'h00};
		span  = longint'(1) << $urandom_range(23);
		v     = ref_t + longint'($urandom_range(1) ? 1 : -1) * (longint'($urandom) % span);
		if (v < 0)
			v = 0;
		if (v > longint'(RAW_MAX))
			v = RAW_MAX;
		return RAW_W'(v);
	endfunction

	function automatic logic [RAW_W-1:0] pick_raw_press();
		case ($urandom_range(9))
			0:       return '0;
			1:       return RAW_MAX;
			default: return RAW_W'($urandom);
		endcase
	endfunction

	task automatic run_random(input int n);
		repeat (n)
			send_pair(pick_raw_press(), pick_raw_temp());
		drain();
	endtask

	initial begin
		cal_t typical, all_max;
		typical = cal_t'{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
		all_max = '1;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 13;
		recv_idle_pct = 62;

		// calibration still at reset
		send_pair('0, '0);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(RAW_MAX, '0);
		send_pair('0, RAW_MAX);
		drain();

		// reference point is 8566784 with these words
		load_cal(typical);
		send_pair(24'd6465444, 24'd8077636);
		send_pair('0, 24'd8566784);          // dT zero
		send_pair(RAW_MAX, 24'd8566783);     // dT -1, truncates back to 20 degrees
		send_pair(RAW_MAX, 24'd8566785);
		send_pair(24'd8000000, 24'd8300000); // cold
		send_pair(24'd8000000, 24'd7500000); // very cold
		send_pair(24'd8000000, '0);
		send_pair(24'd8000000, 24'd9400000); // hot
		send_pair(24'd8000000, RAW_MAX);
		send_pair(24'd1, 24'd8200000);
		send_pair(24'h800000, 24'h800000);
		send_pair(24'h555555, 24'hAAAAAA);
		send_pair(24'hAAAAAA, 24'h555555);
		drain();

		load_cal(all_max);
		send_pair(RAW_MAX, RAW_MAX);
		send_pair(RAW_MAX, '0);
		send_pair('0, '0);
		send_pair(RAW_MAX, 24'hFFFEFF);
		drain();

		load_cal(typical);
		run_random(PHASE_ITEMS);
		load_cal(rand_cal());
		run_random(PHASE_ITEMS);
		load_cal('0);
		run_random(PHASE_ITEMS);

		send_idle_pct = 62;
		recv_idle_pct = 13;
		load_cal(rand_cal());
		run_random(PHASE_ITEMS);
		load_cal(all_max);
		run_random(PHASE_ITEMS);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		load_cal(rand_cal());
		hold_go <= 1'b1;   // long output stall while input keeps coming
		run_random(PHASE_ITEMS);
		load_cal(rand_cal());
		run_random(PHASE_ITEMS);

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("tb_barometric_pressure_compensation: PASS");
		else
			$display("tb_barometric_pressure_compensation: FAIL");
		$finish;
	end

endmodule
